// File: src/swec_pkg.sv
// Package for the sliding window event counter.
// Sizes, register indexes, input kind codes, cell and controller types.
// No dependencies.
package swec_pkg;

    localparam int NUM_BUCKETS = 16;
    localparam int TIME_BITS   = 48;
    localparam int HIT_BITS    = 16;
    localparam int BW_BITS     = 32;
    localparam int TOTAL_BITS  = 24;

    localparam int IDX_W   = $clog2(NUM_BUCKETS);
    localparam int USED_W  = $clog2(NUM_BUCKETS + 1);
    localparam int DCNT_W  = $clog2(TIME_BITS + 1);
    localparam int SUM_W   = ((TOTAL_BITS > HIT_BITS) ? TOTAL_BITS : HIT_BITS) + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = (TIME_BITS > BW_BITS) ? TIME_BITS : BW_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_WIDTH  = 1'b1;

    localparam logic [TIME_BITS-1:0] WINDOW_RESET = TIME_BITS'(64'd1000000000);
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX   = {TOTAL_BITS{1'b1}};
    localparam logic [HIT_BITS-1:0]   HITS_MAX    = {HIT_BITS{1'b1}};

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_BUMP
    } t_cell_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_APPLY,
        S_WALK,
        S_OUT
    } t_state;

endpackage

// File: src/swec_if.sv
// Valid/ready channel interfaces for input and result words.
// Depends on swec_pkg.
interface swec_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [swec_pkg::TIME_BITS-1:0] now;

    modport source (output valid, output kind, output now, input ready);
    modport sink   (input valid, input kind, input now, output ready);
endinterface

interface swec_out_if;
    logic                            valid;
    logic                            ready;
    logic [swec_pkg::TOTAL_BITS-1:0] event_total;
    logic [swec_pkg::USED_W-1:0]     buckets_used;
    logic                            overflowed;

    modport source (output valid, output event_total, output buckets_used,
                    output overflowed, input ready);
    modport sink   (input valid, input event_total, input buckets_used,
                    input overflowed, output ready);
endinterface

// File: src/swec_div.sv
// Restoring remainder unit, one dividend bit per cycle.
// Gives now mod bucket_width for the rounding step. Depends on swec_pkg.
module swec_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [swec_pkg::TIME_BITS-1:0] i_dividend,
    input  logic [swec_pkg::BW_BITS-1:0]   i_divisor,
    output logic                           o_done,
    output logic [swec_pkg::BW_BITS-1:0]   o_rem
);
    logic [swec_pkg::BW_BITS-1:0]   r_rem, n_rem;
    logic [swec_pkg::TIME_BITS-1:0] r_dq;
    logic [swec_pkg::BW_BITS-1:0]   r_dvs;
    logic [swec_pkg::DCNT_W-1:0]    r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [swec_pkg::BW_BITS:0]     w_sh;

    always_comb begin
        w_sh = {r_rem, r_dq[swec_pkg::TIME_BITS-1]};
        if (w_sh >= {1'b0, r_dvs}) begin
            n_rem = swec_pkg::BW_BITS'(w_sh - {1'b0, r_dvs});
        end else begin
            n_rem = w_sh[swec_pkg::BW_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= swec_pkg::DCNT_W'(swec_pkg::TIME_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == swec_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dq  <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dq  <= {r_dq[swec_pkg::TIME_BITS-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// File: src/swec_cell.sv
// One bucket cell of the chain: bucket time and saturating hit count.
// Takes its neighbour's bucket on shift. Depends on swec_pkg.
module swec_cell (
    input  logic                           i_clk,
    input  swec_pkg::t_cell_op             i_op,
    input  logic [swec_pkg::TIME_BITS-1:0] i_time,
    input  logic [swec_pkg::HIT_BITS-1:0]  i_hits,
    output logic [swec_pkg::TIME_BITS-1:0] o_time,
    output logic [swec_pkg::HIT_BITS-1:0]  o_hits
);
    logic [swec_pkg::TIME_BITS-1:0] r_time, n_time;
    logic [swec_pkg::HIT_BITS-1:0]  r_hits, n_hits;

    always_comb begin
        n_time = r_time;
        n_hits = r_hits;
        case (i_op)
            swec_pkg::CELL_SHIFT: begin
                n_time = i_time;
                n_hits = i_hits;
            end
            swec_pkg::CELL_BUMP: begin
                if (r_hits != swec_pkg::HITS_MAX) begin
                    n_hits = r_hits + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_time <= n_time;
        r_hits <= n_hits;
    end

    assign o_time = r_time;
    assign o_hits = r_hits;
endmodule

// File: src/sliding_window_event_counter.sv
// Sliding window event counter: a chain of bucket cells, newest bucket in
// cell 0, oldest at cell buckets_used-1, run by a small controller. An event
// word with a non-zero bucket_width is first rounded down to a bucket start
// by the one-bit-per-cycle remainder unit. On a query word the chain turns
// once round, oldest bucket first past the purge and sum logic, and is back
// in place at the end. A result is held in an output register until taken;
// the next word is accepted meanwhile. Words are taken one at a time, on the
// input channel only when the controller is idle. Configuration may be
// written while idle. Depends on swec_pkg, swec_if, swec_div and swec_cell.
module sliding_window_event_counter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [swec_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [swec_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    swec_in_if.sink                              i_in,
    swec_out_if.source                           o_out
);
    localparam int N  = swec_pkg::NUM_BUCKETS;
    localparam int TB = swec_pkg::TIME_BITS;
    localparam int HB = swec_pkg::HIT_BITS;

    swec_pkg::t_state r_state, n_state;

    logic [TB-1:0]                   r_wl;
    logic [swec_pkg::BW_BITS-1:0]    r_bw;
    logic                            r_kind;
    logic [TB-1:0]                   r_now;
    logic [TB-1:0]                   r_t;
    logic [TB-1:0]                   r_begin;
    logic                            r_purging;
    logic [swec_pkg::USED_W-1:0]     r_used;
    logic [swec_pkg::USED_W-1:0]     r_kept, n_kept;
    logic [swec_pkg::TOTAL_BITS-1:0] r_sum, n_sum;
    logic                            n_purging;
    logic [swec_pkg::IDX_W-1:0]      r_step;
    logic                            r_ovf;
    logic                            r_out_valid;
    logic [swec_pkg::TOTAL_BITS-1:0] r_out_total;
    logic [swec_pkg::USED_W-1:0]     r_out_used;
    logic                            r_out_ovf;

    logic                            w_in_ready;
    logic                            w_in_fire;
    logic                            w_out_free;
    logic                            w_load_out;
    logic                            w_last_step;
    logic                            w_bump;
    swec_pkg::t_cell_op              w_op;
    logic                            w_div_start;
    logic                            w_div_done;
    logic [swec_pkg::BW_BITS-1:0]    w_rem;
    logic [TB+swec_pkg::BW_BITS-1:0] w_round;
    logic [TB-1:0]                   w_feed_time;
    logic [HB-1:0]                   w_feed_hits;
    logic [swec_pkg::IDX_W-1:0]      w_idx;
    logic                            w_entry_ok;
    logic [swec_pkg::SUM_W-1:0]      w_sum_wide;

    logic [TB-1:0] w_time [N];
    logic [HB-1:0] w_hits [N];

    // ---------------- cell chain
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            if (g == 0) begin : g_head
                swec_cell u_cell (
                    .i_clk  (i_clk),
                    .i_op   (w_op),
                    .i_time (w_feed_time),
                    .i_hits (w_feed_hits),
                    .o_time (w_time[g]),
                    .o_hits (w_hits[g])
                );
            end else begin : g_body
                swec_cell u_cell (
                    .i_clk  (i_clk),
                    .i_op   ((w_op == swec_pkg::CELL_BUMP) ? swec_pkg::CELL_HOLD : w_op),
                    .i_time (w_time[g-1]),
                    .i_hits (w_hits[g-1]),
                    .o_time (w_time[g]),
                    .o_hits (w_hits[g])
                );
            end
        end
    endgenerate

    // new bucket enters at the head on an event, the tail wraps round on a walk
    assign w_feed_time = (r_state == swec_pkg::S_WALK) ? w_time[N-1] : r_t;
    assign w_feed_hits = (r_state == swec_pkg::S_WALK) ? w_hits[N-1] : HB'(1);

    // ---------------- remainder unit
    // started on the accepting edge, so it takes the time straight off the channel
    swec_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_in.now),
        .i_divisor  (r_bw),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    assign w_round = {{swec_pkg::BW_BITS{1'b0}}, r_now} - {{TB{1'b0}}, w_rem};

    // ---------------- walk datapath
    assign w_idx       = swec_pkg::IDX_W'(N - 1) - r_step;
    assign w_entry_ok  = (swec_pkg::USED_W'(w_idx) < r_used);
    assign w_last_step = (r_step == swec_pkg::IDX_W'(N - 1));
    assign w_sum_wide  = swec_pkg::SUM_W'(r_sum) + swec_pkg::SUM_W'(w_hits[N-1]);

    always_comb begin
        n_kept    = r_kept;
        n_sum     = r_sum;
        n_purging = r_purging;
        if (w_entry_ok) begin
            if (r_purging && (w_time[N-1] < r_begin)) begin
                n_kept = r_kept;
            end else begin
                n_purging = 1'b0;
                n_kept    = r_kept + 1'b1;
                if (w_sum_wide > swec_pkg::SUM_W'(swec_pkg::TOTAL_MAX)) begin
                    n_sum = swec_pkg::TOTAL_MAX;
                end else begin
                    n_sum = w_sum_wide[swec_pkg::TOTAL_BITS-1:0];
                end
            end
        end
    end

    assign w_bump     = (r_used != '0) && (w_time[0] == r_t);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_in_fire  = i_in.valid && w_in_ready;

    // ---------------- controller: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swec_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    if (i_in.kind == swec_pkg::KIND_QUERY) begin
                        n_state = swec_pkg::S_WALK;
                    end else if (r_bw == '0) begin
                        n_state = swec_pkg::S_APPLY;
                    end else begin
                        n_state = swec_pkg::S_DIV;
                    end
                end
            end
            swec_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = swec_pkg::S_APPLY;
                end
            end
            swec_pkg::S_APPLY: begin
                n_state = swec_pkg::S_IDLE;
            end
            swec_pkg::S_WALK: begin
                if (w_last_step) begin
                    n_state = swec_pkg::S_OUT;
                end
            end
            swec_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = swec_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swec_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- controller: outputs
    always_comb begin
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_op        = swec_pkg::CELL_HOLD;
        w_load_out  = 1'b0;
        case (r_state)
            swec_pkg::S_IDLE: begin
                w_in_ready  = 1'b1;
                w_div_start = i_in.valid && (i_in.kind == swec_pkg::KIND_EVENT)
                              && (r_bw != '0);
            end
            swec_pkg::S_APPLY: begin
                w_op = w_bump ? swec_pkg::CELL_BUMP : swec_pkg::CELL_SHIFT;
            end
            swec_pkg::S_WALK: begin
                w_op = swec_pkg::CELL_SHIFT;
            end
            swec_pkg::S_OUT: begin
                w_load_out = w_out_free;
            end
            default: begin
            end
        endcase
    end

    // ---------------- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swec_pkg::S_IDLE;
            r_wl        <= swec_pkg::WINDOW_RESET;
            r_bw        <= '0;
            r_used      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    swec_pkg::CFG_WINDOW_LENGTH: r_wl <= i_cfg_data[TB-1:0];
                    swec_pkg::CFG_BUCKET_WIDTH:  r_bw <= i_cfg_data[swec_pkg::BW_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if ((r_state == swec_pkg::S_APPLY) && !w_bump) begin
                if (r_used == swec_pkg::USED_W'(N)) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_used <= r_used + 1'b1;
                end
            end
            if ((r_state == swec_pkg::S_WALK) && w_last_step) begin
                r_used <= n_kept;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_kind    <= i_in.kind;
            r_now     <= i_in.now;
            r_t       <= i_in.now;
            r_begin   <= i_in.now - r_wl;
            r_purging <= (i_in.now >= r_wl);
            r_step    <= '0;
            r_kept    <= '0;
            r_sum     <= '0;
        end
        if ((r_state == swec_pkg::S_DIV) && w_div_done) begin
            r_t <= w_round[TB-1:0];
        end
        if (r_state == swec_pkg::S_WALK) begin
            r_step    <= r_step + 1'b1;
            r_kept    <= n_kept;
            r_sum     <= n_sum;
            r_purging <= n_purging;
        end
        if (w_load_out) begin
            r_out_total <= r_sum;
            r_out_used  <= r_used;
            r_out_ovf   <= r_ovf;
        end
    end

    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.event_total  = r_out_total;
    assign o_out.buckets_used = r_out_used;
    assign o_out.overflowed   = r_out_ovf;

    // ---------------- checks
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= swec_pkg::USED_W'(N))
        else $error("bucket count beyond chain length");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag cleared");

    a_query_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (i_in.kind == swec_pkg::KIND_QUERY)) |=>
            (r_state == swec_pkg::S_WALK))
        else $error("query word did not start a walk");

    a_apply_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swec_pkg::S_APPLY) |=>
            ((r_used == $past(r_used)) || (r_used == $past(r_used) + 1'b1)))
        else $error("event changed bucket count by more than one");

    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swec_pkg::S_WALK) |-> (r_kept <= r_used))
        else $error("walk kept more buckets than held");

    a_kind_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swec_pkg::S_DIV) |-> (r_kind == swec_pkg::KIND_EVENT))
        else $error("rounding started for a query word");
endmodule
